// File: sv/bxd_pkg.sv
// ----------------------------------------------------------------------------
// Box area downscaler package
// Shared widths, item types, register codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bxd_pkg;

    // Default size limits, handed to the top level parameters.
    localparam int MAX_SOURCE_DIM_DEF = 4096;
    localparam int MAX_TARGET_DIM_DEF = 256;

    // Fixed field widths.
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SRC_CFG_W  = 13;
    localparam int TGT_CFG_W  = 9;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH  = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } cfg_reg_t;

    // One source pixel request.
    typedef struct packed {
        logic             frame_start;
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } in_item_t;

    // One output pixel request.
    typedef struct packed {
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [PIX_W-1:0]   red_out;
        logic [PIX_W-1:0]   green_out;
        logic [PIX_W-1:0]   blue_out;
        logic               frame_end;
    } out_item_t;

    // Which cell boundary the bound divider computes.
    typedef enum logic [1:0] {
        BND_COL_FIRST,
        BND_ROW_FIRST,
        BND_COL_NEXT,
        BND_ROW_NEXT
    } bound_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RST_COL_WAIT,
        ST_RST_ROW_WAIT,
        ST_RESTART,
        ST_PIX,
        ST_SUM,
        ST_AVG,
        ST_EMIT,
        ST_ADV,
        ST_COL_BND,
        ST_ROW_BND,
        ST_BND_WAIT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       accept;
        logic       bnd_start;
        bound_sel_t bnd_sel;
        logic       restart;
        logic       pix;
        logic       fold;
        logic       avg_start;
        logic       emit;
        logic       advance;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic restart_req;
        logic last_col;
        logic last_row;
        logic bnd_done;
        logic avg_done;
        logic out_free;
        logic need_col_bnd;
        logic need_row_bnd;
    } dp_status_t;

endpackage

// File: sv/box_area_average_downscaler.sv
// ----------------------------------------------------------------------------
// Box area average downscaler
// Source RGB pixels arrive in raster order on the input channel; each output
// cell's channel averages leave on the output channel when its last pixel is
// in. Both channels use valid and stall; configuration is a plain write port.
//
// One pixel is taken at a time. A pixel that closes a cell column, or the
// last cell of a row of cells that is not the final row, waits for the next
// boundary k*S/T from the iterative divider, a DIM_W-bit quotient where
// DIM_W = clog2(MAX_SOURCE_DIM + 1). A pixel that finishes a cell also waits
// for the three 8-step average dividers and the output register load.
// The first pixel after reset, a configuration write or frame_start first
// computes both first cell boundaries.
// Reset sets all sizes to 1 and restarts the frame at pixel (0,0).
// The output register holds a finished request while the receiver stalls;
// the block stops before loading the next result until that one is taken.
// ----------------------------------------------------------------------------
module box_area_average_downscaler #(
    parameter int MAX_SOURCE_DIM = bxd_pkg::MAX_SOURCE_DIM_DEF,
    parameter int MAX_TARGET_DIM = bxd_pkg::MAX_TARGET_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bxd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bxd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bxd_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bxd_pkg::out_item_t            out_data
);

    bxd_pkg::dp_cmd_t    cmd;
    bxd_pkg::dp_status_t status;

    // Sequencer.
    bxd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    bxd_dpath #(
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .MAX_TARGET_DIM (MAX_TARGET_DIM)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: sv/bxd_div.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces a QUOT_W-bit quotient, one bit per cycle, for a dividend known to
// be below the divisor shifted left by QUOT_W. Pulses done when finished.
// ----------------------------------------------------------------------------
module bxd_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 24,
    parameter int QUOT_W     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);

    localparam int DEN_W  = DIVISOR_W + QUOT_W;
    localparam int CMP_W  = (DIVIDEND_W > DEN_W) ? DIVIDEND_W : DEN_W;
    localparam int STEP_W = $clog2(QUOT_W + 1);

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [CMP_W-1:0] rem_x;
    logic [CMP_W-1:0] den_x;
    logic [CMP_W-1:0] diff;
    logic             ge;

    // Trial subtraction of the shifted divisor.
    always_comb
    begin
        rem_x = CMP_W'(rem_reg);
        den_x = CMP_W'(den_reg);
        ge    = (rem_x >= den_x);
        diff  = rem_x - den_x;
    end

    // Control: busy flag, step count and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(QUOT_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Data: remainder, shifted divisor and quotient bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            den_reg  <= DEN_W'(divisor) << (QUOT_W - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= DIVIDEND_W'(diff);
            end
            den_reg  <= den_reg >> 1;
            quot_reg <= (quot_reg << 1) | QUOT_W'(ge);
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: sv/bxd_ctrl.sv
// ----------------------------------------------------------------------------
// Box area downscaler controller
// Sequences one source pixel at a time through restart, accumulation,
// averaging, output and position advance, driving the datapath by commands.
// ----------------------------------------------------------------------------
module bxd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bxd_pkg::dp_status_t status,
    output bxd_pkg::dp_cmd_t    cmd
);

    bxd_pkg::state_t state_reg;
    bxd_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bxd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.bnd_sel   = bxd_pkg::BND_COL_FIRST;
        in_stall      = 1'b1;
        unique case (state_reg)
            bxd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = bxd_pkg::ST_CHECK;
                end
            end
            bxd_pkg::ST_CHECK:
            begin
                if (status.restart_req)
                begin
                    cmd.bnd_start = 1'b1;
                    cmd.bnd_sel   = bxd_pkg::BND_COL_FIRST;
                    state_next    = bxd_pkg::ST_RST_COL_WAIT;
                end
                else
                begin
                    state_next = bxd_pkg::ST_PIX;
                end
            end
            bxd_pkg::ST_RST_COL_WAIT:
            begin
                if (status.bnd_done)
                begin
                    cmd.bnd_start = 1'b1;
                    cmd.bnd_sel   = bxd_pkg::BND_ROW_FIRST;
                    state_next    = bxd_pkg::ST_RST_ROW_WAIT;
                end
            end
            bxd_pkg::ST_RST_ROW_WAIT:
            begin
                if (status.bnd_done)
                begin
                    state_next = bxd_pkg::ST_RESTART;
                end
            end
            bxd_pkg::ST_RESTART:
            begin
                cmd.restart = 1'b1;
                state_next  = bxd_pkg::ST_PIX;
            end
            bxd_pkg::ST_PIX:
            begin
                cmd.pix    = 1'b1;
                state_next = bxd_pkg::ST_SUM;
            end
            bxd_pkg::ST_SUM:
            begin
                cmd.fold = 1'b1;
                if (status.last_col && status.last_row)
                begin
                    cmd.avg_start = 1'b1;
                    state_next    = bxd_pkg::ST_AVG;
                end
                else
                begin
                    state_next = bxd_pkg::ST_ADV;
                end
            end
            bxd_pkg::ST_AVG:
            begin
                if (status.avg_done)
                begin
                    state_next = bxd_pkg::ST_EMIT;
                end
            end
            bxd_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = bxd_pkg::ST_ADV;
                end
            end
            bxd_pkg::ST_ADV:
            begin
                cmd.advance = 1'b1;
                priority if (status.need_col_bnd)
                begin
                    state_next = bxd_pkg::ST_COL_BND;
                end
                else if (status.need_row_bnd)
                begin
                    state_next = bxd_pkg::ST_ROW_BND;
                end
                else
                begin
                    state_next = bxd_pkg::ST_IDLE;
                end
            end
            bxd_pkg::ST_COL_BND:
            begin
                cmd.bnd_start = 1'b1;
                cmd.bnd_sel   = bxd_pkg::BND_COL_NEXT;
                state_next    = bxd_pkg::ST_BND_WAIT;
            end
            bxd_pkg::ST_ROW_BND:
            begin
                cmd.bnd_start = 1'b1;
                cmd.bnd_sel   = bxd_pkg::BND_ROW_NEXT;
                state_next    = bxd_pkg::ST_BND_WAIT;
            end
            bxd_pkg::ST_BND_WAIT:
            begin
                if (status.bnd_done)
                begin
                    state_next = bxd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bxd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/bxd_dpath.sv
// ----------------------------------------------------------------------------
// Box area downscaler datapath
// Configuration registers, frame position, running and per-column band sums,
// the cell boundary divider, the three channel average dividers and the
// output register.
// ----------------------------------------------------------------------------
module bxd_dpath #(
    parameter int MAX_SOURCE_DIM = bxd_pkg::MAX_SOURCE_DIM_DEF,
    parameter int MAX_TARGET_DIM = bxd_pkg::MAX_TARGET_DIM_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bxd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bxd_pkg::CFG_W-1:0]           cfg_data,
    input  bxd_pkg::in_item_t                   in_data,
    input  logic                                out_stall,
    output logic                                out_valid,
    output bxd_pkg::out_item_t                  out_data,
    input  bxd_pkg::dp_cmd_t                    cmd,
    output bxd_pkg::dp_status_t                 status
);

    localparam int DIM_W  = $clog2(MAX_SOURCE_DIM + 1);
    localparam int POS_W  = $clog2(MAX_SOURCE_DIM);
    localparam int CELL_W = $clog2(MAX_TARGET_DIM + 1);
    localparam int IDX_W  = (MAX_TARGET_DIM > 1) ? $clog2(MAX_TARGET_DIM) : 1;
    localparam int RUN_W  = DIM_W + bxd_pkg::PIX_W;
    localparam int CNT_W  = 2 * DIM_W;
    localparam int SUM_W  = CNT_W + bxd_pkg::PIX_W;
    localparam int NUM_W  = CELL_W + DIM_W;
    localparam int EXT_A  = (DIM_W > CELL_W) ? DIM_W : CELL_W;
    localparam int EXT_W  = ((EXT_A > bxd_pkg::CFG_W) ? EXT_A : bxd_pkg::CFG_W) + 1;

    // Configuration registers.
    logic [bxd_pkg::SRC_CFG_W-1:0] src_w_reg;
    logic [bxd_pkg::SRC_CFG_W-1:0] src_h_reg;
    logic [bxd_pkg::TGT_CFG_W-1:0] tgt_w_reg;
    logic [bxd_pkg::TGT_CFG_W-1:0] tgt_h_reg;
    logic                          restart_pend_reg;

    // Captured pixel.
    bxd_pkg::in_item_t pix_reg;

    // Frame position.
    logic [POS_W-1:0]  src_col_reg;
    logic [POS_W-1:0]  src_row_reg;
    logic [CELL_W-1:0] cell_col_reg;
    logic [CELL_W-1:0] cell_row_reg;
    logic [DIM_W-1:0]  col_lo_reg;
    logic [DIM_W-1:0]  col_hi_reg;
    logic [DIM_W-1:0]  row_lo_reg;
    logic [DIM_W-1:0]  row_hi_reg;
    logic [DIM_W-1:0]  col_first_reg;
    logic [DIM_W-1:0]  row_first_reg;

    // Sums.
    logic [RUN_W-1:0] run_red_reg;
    logic [RUN_W-1:0] run_green_reg;
    logic [RUN_W-1:0] run_blue_reg;
    logic [SUM_W-1:0] rd_red_reg;
    logic [SUM_W-1:0] rd_green_reg;
    logic [SUM_W-1:0] rd_blue_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [SUM_W-1:0] red_col_mem   [MAX_TARGET_DIM];
    logic [SUM_W-1:0] green_col_mem [MAX_TARGET_DIM];
    logic [SUM_W-1:0] blue_col_mem  [MAX_TARGET_DIM];

    // Bound divider control.
    bxd_pkg::bound_sel_t bnd_sel_reg;

    // Output register.
    logic               out_valid_reg;
    bxd_pkg::out_item_t out_reg;

    // Effective sizes.
    logic [EXT_W-1:0] sw_x;
    logic [EXT_W-1:0] sh_x;
    logic [EXT_W-1:0] tw_x;
    logic [EXT_W-1:0] th_x;
    logic [EXT_W-1:0] tw_hi;
    logic [EXT_W-1:0] th_hi;
    logic [DIM_W-1:0] sw_eff;
    logic [DIM_W-1:0] sh_eff;
    logic [CELL_W-1:0] tw_eff;
    logic [CELL_W-1:0] th_eff;

    // Position flags.
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_next;
    logic             last_col;
    logic             last_row;
    logic             first_row;
    logic             col_wrap;
    logic             row_wrap;
    logic [IDX_W-1:0] idx;

    // Fold and divider signals.
    logic [SUM_W-1:0]  tot_red;
    logic [SUM_W-1:0]  tot_green;
    logic [SUM_W-1:0]  tot_blue;
    logic [CELL_W-1:0] bnd_k;
    logic [DIM_W-1:0]  bnd_s;
    logic [CELL_W-1:0] bnd_t;
    logic [NUM_W-1:0]  bnd_num;
    logic              bnd_done;
    logic [DIM_W-1:0]  bnd_q;
    logic              avg_done_r;
    logic              avg_done_g;
    logic              avg_done_b;
    logic [bxd_pkg::PIX_W-1:0] avg_r;
    logic [bxd_pkg::PIX_W-1:0] avg_g;
    logic [bxd_pkg::PIX_W-1:0] avg_b;
    logic              out_free;
    logic              frame_end;

    // Clamp the configured sizes to their working ranges.
    always_comb
    begin
        sw_x = EXT_W'(src_w_reg);
        if (sw_x == '0)
        begin
            sw_x = EXT_W'(1);
        end
        else if (sw_x > EXT_W'(MAX_SOURCE_DIM))
        begin
            sw_x = EXT_W'(MAX_SOURCE_DIM);
        end
        sh_x = EXT_W'(src_h_reg);
        if (sh_x == '0)
        begin
            sh_x = EXT_W'(1);
        end
        else if (sh_x > EXT_W'(MAX_SOURCE_DIM))
        begin
            sh_x = EXT_W'(MAX_SOURCE_DIM);
        end
        tw_hi = (sw_x < EXT_W'(MAX_TARGET_DIM)) ? sw_x : EXT_W'(MAX_TARGET_DIM);
        th_hi = (sh_x < EXT_W'(MAX_TARGET_DIM)) ? sh_x : EXT_W'(MAX_TARGET_DIM);
        tw_x  = EXT_W'(tgt_w_reg);
        if (tw_x == '0)
        begin
            tw_x = EXT_W'(1);
        end
        else if (tw_x > tw_hi)
        begin
            tw_x = tw_hi;
        end
        th_x = EXT_W'(tgt_h_reg);
        if (th_x == '0)
        begin
            th_x = EXT_W'(1);
        end
        else if (th_x > th_hi)
        begin
            th_x = th_hi;
        end
        sw_eff = DIM_W'(sw_x);
        sh_eff = DIM_W'(sh_x);
        tw_eff = CELL_W'(tw_x);
        th_eff = CELL_W'(th_x);
    end

    // Position flags for the current pixel.
    always_comb
    begin
        col_next  = DIM_W'(src_col_reg) + DIM_W'(1);
        row_next  = DIM_W'(src_row_reg) + DIM_W'(1);
        last_col  = (col_next == col_hi_reg);
        last_row  = (row_next == row_hi_reg);
        first_row = (DIM_W'(src_row_reg) == row_lo_reg);
        col_wrap  = (col_next >= sw_eff);
        row_wrap  = (row_next >= sh_eff);
        idx       = cell_col_reg[IDX_W-1:0];
        frame_end = ((cell_col_reg + CELL_W'(1)) == tw_eff)
                 && ((cell_row_reg + CELL_W'(1)) == th_eff);
    end

    // Configuration writes; any write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg        <= bxd_pkg::SRC_CFG_W'(1);
            src_h_reg        <= bxd_pkg::SRC_CFG_W'(1);
            tgt_w_reg        <= bxd_pkg::TGT_CFG_W'(1);
            tgt_h_reg        <= bxd_pkg::TGT_CFG_W'(1);
            restart_pend_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (bxd_pkg::cfg_reg_t'(cfg_index))
                bxd_pkg::REG_SOURCE_WIDTH:  src_w_reg <= cfg_data[bxd_pkg::SRC_CFG_W-1:0];
                bxd_pkg::REG_SOURCE_HEIGHT: src_h_reg <= cfg_data[bxd_pkg::SRC_CFG_W-1:0];
                bxd_pkg::REG_TARGET_WIDTH:  tgt_w_reg <= cfg_data[bxd_pkg::TGT_CFG_W-1:0];
                bxd_pkg::REG_TARGET_HEIGHT: tgt_h_reg <= cfg_data[bxd_pkg::TGT_CFG_W-1:0];
                default:                    src_w_reg <= src_w_reg;
            endcase
            restart_pend_reg <= 1'b1;
        end
        else if (cmd.restart)
        begin
            restart_pend_reg <= 1'b0;
        end
    end

    // Pixel capture on acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= in_data;
        end
    end

    // Frame position, boundaries and the first-cell boundaries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            cell_col_reg  <= '0;
            cell_row_reg  <= '0;
            col_lo_reg    <= '0;
            col_hi_reg    <= '0;
            row_lo_reg    <= '0;
            row_hi_reg    <= '0;
            col_first_reg <= '0;
            row_first_reg <= '0;
        end
        else
        begin
            if (bnd_done)
            begin
                unique case (bnd_sel_reg)
                    bxd_pkg::BND_COL_FIRST: col_first_reg <= bnd_q;
                    bxd_pkg::BND_ROW_FIRST: row_first_reg <= bnd_q;
                    bxd_pkg::BND_COL_NEXT:  col_hi_reg    <= bnd_q;
                    bxd_pkg::BND_ROW_NEXT:  row_hi_reg    <= bnd_q;
                    default:                col_hi_reg    <= col_hi_reg;
                endcase
            end
            if (cmd.restart)
            begin
                src_col_reg  <= '0;
                src_row_reg  <= '0;
                cell_col_reg <= '0;
                cell_row_reg <= '0;
                col_lo_reg   <= '0;
                col_hi_reg   <= col_first_reg;
                row_lo_reg   <= '0;
                row_hi_reg   <= row_first_reg;
            end
            else if (cmd.advance)
            begin
                if (!last_col)
                begin
                    src_col_reg <= src_col_reg + POS_W'(1);
                end
                else if (col_wrap)
                begin
                    src_col_reg  <= '0;
                    cell_col_reg <= '0;
                    col_lo_reg   <= '0;
                    col_hi_reg   <= col_first_reg;
                    if (last_row && row_wrap)
                    begin
                        src_row_reg  <= '0;
                        cell_row_reg <= '0;
                        row_lo_reg   <= '0;
                        row_hi_reg   <= row_first_reg;
                    end
                    else if (last_row)
                    begin
                        src_row_reg  <= src_row_reg + POS_W'(1);
                        cell_row_reg <= cell_row_reg + CELL_W'(1);
                        row_lo_reg   <= row_hi_reg;
                    end
                    else
                    begin
                        src_row_reg <= src_row_reg + POS_W'(1);
                    end
                end
                else
                begin
                    src_col_reg  <= src_col_reg + POS_W'(1);
                    cell_col_reg <= cell_col_reg + CELL_W'(1);
                    col_lo_reg   <= col_hi_reg;
                end
            end
        end
    end

    // Running sums, band sum read and cell pixel count.
    always_ff @(posedge clk)
    begin
        if (cmd.pix)
        begin
            if (DIM_W'(src_col_reg) == col_lo_reg)
            begin
                run_red_reg   <= RUN_W'(pix_reg.red_in);
                run_green_reg <= RUN_W'(pix_reg.green_in);
                run_blue_reg  <= RUN_W'(pix_reg.blue_in);
            end
            else
            begin
                run_red_reg   <= run_red_reg + RUN_W'(pix_reg.red_in);
                run_green_reg <= run_green_reg + RUN_W'(pix_reg.green_in);
                run_blue_reg  <= run_blue_reg + RUN_W'(pix_reg.blue_in);
            end
            rd_red_reg   <= red_col_mem[idx];
            rd_green_reg <= green_col_mem[idx];
            rd_blue_reg  <= blue_col_mem[idx];
            cnt_reg      <= CNT_W'(col_hi_reg - col_lo_reg) * CNT_W'(row_hi_reg - row_lo_reg);
        end
    end

    // Cell totals: running sum plus the band sum from earlier rows.
    always_comb
    begin
        tot_red   = SUM_W'(run_red_reg) + (first_row ? '0 : rd_red_reg);
        tot_green = SUM_W'(run_green_reg) + (first_row ? '0 : rd_green_reg);
        tot_blue  = SUM_W'(run_blue_reg) + (first_row ? '0 : rd_blue_reg);
    end

    // Band sums per cell column.
    always_ff @(posedge clk)
    begin
        if (cmd.fold && last_col && !last_row)
        begin
            red_col_mem[idx]   <= tot_red;
            green_col_mem[idx] <= tot_green;
            blue_col_mem[idx]  <= tot_blue;
        end
    end

    // Boundary divider operands: k * s / t.
    always_comb
    begin
        unique case (cmd.bnd_sel)
            bxd_pkg::BND_COL_FIRST:
            begin
                bnd_k = CELL_W'(1);
                bnd_s = sw_eff;
                bnd_t = tw_eff;
            end
            bxd_pkg::BND_ROW_FIRST:
            begin
                bnd_k = CELL_W'(1);
                bnd_s = sh_eff;
                bnd_t = th_eff;
            end
            bxd_pkg::BND_COL_NEXT:
            begin
                bnd_k = cell_col_reg + CELL_W'(1);
                bnd_s = sw_eff;
                bnd_t = tw_eff;
            end
            bxd_pkg::BND_ROW_NEXT:
            begin
                bnd_k = cell_row_reg + CELL_W'(1);
                bnd_s = sh_eff;
                bnd_t = th_eff;
            end
            default:
            begin
                bnd_k = CELL_W'(1);
                bnd_s = sw_eff;
                bnd_t = tw_eff;
            end
        endcase
        bnd_num = NUM_W'(bnd_k) * NUM_W'(bnd_s);
    end

    // Remember which boundary is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_sel_reg <= bxd_pkg::BND_COL_FIRST;
        end
        else if (cmd.bnd_start)
        begin
            bnd_sel_reg <= cmd.bnd_sel;
        end
    end

    bxd_div #(
        .DIVIDEND_W (NUM_W),
        .DIVISOR_W  (CELL_W),
        .QUOT_W     (DIM_W)
    ) u_bnd_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.bnd_start),
        .dividend (bnd_num),
        .divisor  (bnd_t),
        .done     (bnd_done),
        .quotient (bnd_q)
    );

    // Channel averages; the quotient never exceeds the pixel range.
    bxd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (bxd_pkg::PIX_W)
    ) u_red_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.avg_start),
        .dividend (tot_red),
        .divisor  (cnt_reg),
        .done     (avg_done_r),
        .quotient (avg_r)
    );

    bxd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (bxd_pkg::PIX_W)
    ) u_green_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.avg_start),
        .dividend (tot_green),
        .divisor  (cnt_reg),
        .done     (avg_done_g),
        .quotient (avg_g)
    );

    bxd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (bxd_pkg::PIX_W)
    ) u_blue_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.avg_start),
        .dividend (tot_blue),
        .divisor  (cnt_reg),
        .done     (avg_done_b),
        .quotient (avg_b)
    );

    // Output register: holds a finished request until it is taken.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.out_col   <= bxd_pkg::COORD_W'(cell_col_reg);
            out_reg.out_row   <= bxd_pkg::COORD_W'(cell_row_reg);
            out_reg.red_out   <= avg_r;
            out_reg.green_out <= avg_g;
            out_reg.blue_out  <= avg_b;
            out_reg.frame_end <= frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Status to the controller.
    always_comb
    begin
        status.restart_req  = restart_pend_reg || pix_reg.frame_start;
        status.last_col     = last_col;
        status.last_row     = last_row;
        status.bnd_done     = bnd_done;
        status.avg_done     = avg_done_r && avg_done_g && avg_done_b;
        status.out_free     = out_free;
        status.need_col_bnd = last_col && !col_wrap;
        status.need_row_bnd = last_col && col_wrap && last_row && !row_wrap;
    end

endmodule

// File: tb/tb_box_area_average_downscaler.sv
// ----------------------------------------------------------------------------
// Box area average downscaler testbench
// Streams source pixels through a range of source and target sizes and
// compares every averaged output cell with an in-bench area-average model.
// Both channels idle and stall at random, in phases, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_box_area_average_downscaler;

    localparam int SRC_MAX    = 4096;
    localparam int TGT_MAX    = 256;
    localparam int SETTLE     = 200;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 600;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [bxd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bxd_pkg::CFG_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    bxd_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    bxd_pkg::out_item_t            out_data;

    // Pixels waiting to be offered and averaged cells awaiting the block.
    bxd_pkg::in_item_t  pixel_q[$];
    bxd_pkg::out_item_t cell_q[$];
    idle_mode_t         idle_mode;
    bit                 hold_req;
    int                 hold_left;
    int                 fail_count;
    int                 quiet_cycles;
    int                 pixels_sent;

    // Area-average model state.
    int unsigned       reg_sw, reg_sh, reg_tw, reg_th;
    int unsigned       col_pos, row_pos, cell_x, cell_y;
    int unsigned       span_c_lo, span_c_hi, span_r_lo, span_r_hi;
    longint unsigned   acc_r, acc_g, acc_b;
    longint unsigned   band_r[TGT_MAX];
    longint unsigned   band_g[TGT_MAX];
    longint unsigned   band_b[TGT_MAX];

    box_area_average_downscaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned eff_src_w();
        return clamp_size(reg_sw, SRC_MAX);
    endfunction

    function automatic int unsigned eff_src_h();
        return clamp_size(reg_sh, SRC_MAX);
    endfunction

    function automatic int unsigned eff_tgt(int unsigned t, int unsigned s);
        return clamp_size(t, (s < TGT_MAX) ? s : TGT_MAX);
    endfunction

    function automatic int unsigned cell_edge(int unsigned k, int unsigned s,
                                              int unsigned t);
        longint unsigned p;
        p = longint'(k) * longint'(s);
        return int'(p / t);
    endfunction

    // Back to source pixel (0,0) with fresh first boundaries.
    function automatic void restart_frame();
        int unsigned sw, sh;
        sw = eff_src_w();
        sh = eff_src_h();
        col_pos = 0; row_pos = 0; cell_x = 0; cell_y = 0;
        acc_r = 0; acc_g = 0; acc_b = 0;
        span_c_lo = 0; span_c_hi = cell_edge(1, sw, eff_tgt(reg_tw, sw));
        span_r_lo = 0; span_r_hi = cell_edge(1, sh, eff_tgt(reg_th, sh));
    endfunction

    function automatic void model_config(bxd_pkg::cfg_reg_t idx, int unsigned v);
        case (idx)
            bxd_pkg::REG_SOURCE_WIDTH:  reg_sw = v & 13'h1FFF;
            bxd_pkg::REG_SOURCE_HEIGHT: reg_sh = v & 13'h1FFF;
            bxd_pkg::REG_TARGET_WIDTH:  reg_tw = v & 9'h1FF;
            bxd_pkg::REG_TARGET_HEIGHT: reg_th = v & 9'h1FF;
            default: ;
        endcase
        restart_frame();
    endfunction

    // Folds one source pixel into the cell sums and queues a finished cell.
    function automatic void average_pixel(bxd_pkg::in_item_t px);
        int unsigned        sw, sh, tw, th, ci;
        bit                 end_col, end_row, top_row;
        longint unsigned    r, g, b, cnt;
        bxd_pkg::out_item_t avg_px;
        if (px.frame_start)
            restart_frame();
        sw = eff_src_w();
        sh = eff_src_h();
        tw = eff_tgt(reg_tw, sw);
        th = eff_tgt(reg_th, sh);
        if (col_pos == span_c_lo)
        begin
            acc_r = 0; acc_g = 0; acc_b = 0;
        end
        acc_r += px.red_in;
        acc_g += px.green_in;
        acc_b += px.blue_in;
        end_col = (col_pos + 1 == span_c_hi);
        end_row = (row_pos + 1 == span_r_hi);
        top_row = (row_pos == span_r_lo);
        ci = cell_x % TGT_MAX;
        if (end_col)
        begin
            r = acc_r; g = acc_g; b = acc_b;
            if (!top_row)
            begin
                r += band_r[ci]; g += band_g[ci]; b += band_b[ci];
            end
            if (end_row)
            begin
                cnt = longint'(span_c_hi - span_c_lo) * longint'(span_r_hi - span_r_lo);
                if (cnt == 0)
                    cnt = 1;
                avg_px.out_col   = cell_x[7:0];
                avg_px.out_row   = cell_y[7:0];
                avg_px.red_out   = 8'(r / cnt);
                avg_px.green_out = 8'(g / cnt);
                avg_px.blue_out  = 8'(b / cnt);
                avg_px.frame_end = (cell_x + 1 == tw) && (cell_y + 1 == th);
                cell_q.push_back(avg_px);
            end
            else
            begin
                band_r[ci] = r; band_g[ci] = g; band_b[ci] = b;
            end
            if (col_pos + 1 >= sw)
            begin
                col_pos = 0; cell_x = 0;
                span_c_lo = 0; span_c_hi = cell_edge(1, sw, tw);
                if (end_row)
                begin
                    if (row_pos + 1 >= sh)
                    begin
                        row_pos = 0; cell_y = 0;
                        span_r_lo = 0; span_r_hi = cell_edge(1, sh, th);
                    end
                    else
                    begin
                        row_pos++; cell_y++;
                        span_r_lo = span_r_hi;
                        span_r_hi = cell_edge(cell_y + 1, sh, th);
                    end
                end
                else
                    row_pos++;
            end
            else
            begin
                col_pos++; cell_x++;
                span_c_lo = span_c_hi;
                span_c_hi = cell_edge(cell_x + 1, sw, tw);
            end
        end
        else
            col_pos++;
    endfunction

    function automatic bit draw_gap(idle_mode_t mine);
        if (idle_mode == mine)
            return $urandom_range(99) < 66;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 20;
        return 1'b0;
    endfunction

    // Pixel driver: a stalled request keeps its payload.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pixel_q.size() > 0 && !draw_gap(IDLE_SENDER))
            begin
                in_data  <= pixel_q.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with an occasional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= draw_gap(IDLE_RECEIVER);
        end
    end

    // Monitor: model the accepted pixels, check the cells, watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (in_valid && !in_stall)
            begin
                quiet_cycles = 0;
                average_pixel(in_data);
            end
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (cell_q.size() == 0)
                begin
                    $error("output request with no cell expected");
                    fail_count++;
                end
                else
                begin
                    bxd_pkg::out_item_t want;
                    want = cell_q.pop_front();
                    if (out_data.out_col !== want.out_col)
                    begin
                        $error("out_col: expected %0d, got %0d", want.out_col, out_data.out_col);
                        fail_count++;
                    end
                    if (out_data.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
                        fail_count++;
                    end
                    if (out_data.red_out !== want.red_out)
                    begin
                        $error("red_out: expected %0d, got %0d", want.red_out, out_data.red_out);
                        fail_count++;
                    end
                    if (out_data.green_out !== want.green_out)
                    begin
                        $error("green_out: expected %0d, got %0d", want.green_out,
                               out_data.green_out);
                        fail_count++;
                    end
                    if (out_data.blue_out !== want.blue_out)
                    begin
                        $error("blue_out: expected %0d, got %0d", want.blue_out,
                               out_data.blue_out);
                        fail_count++;
                    end
                    if (out_data.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0d, got %0d", want.frame_end,
                               out_data.frame_end);
                        fail_count++;
                    end
                end
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic bxd_pkg::in_item_t rand_pixel(int start_pct);
        bxd_pkg::in_item_t px;
        px.frame_start = $urandom_range(99) < start_pct;
        px.red_in      = 8'($urandom);
        px.green_in    = 8'($urandom);
        px.blue_in     = 8'($urandom);
        return px;
    endfunction

    // Waits until every pixel is in, every cell out and the block is idle again,
    // sampling between edges, then lets the block settle.
    task automatic drain();
        while (pixel_q.size() > 0 || in_valid || cell_q.size() > 0 || in_stall || out_valid)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_sizes(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th);
        int unsigned vals[4];
        vals = '{sw, sh, tw, th};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= bxd_pkg::cfg_reg_t'(i);
            cfg_data  <= bxd_pkg::CFG_W'(vals[i]);
            model_config(bxd_pkg::cfg_reg_t'(i), vals[i]);
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_pixels(int count, int start_pct);
        for (int i = 0; i < count; i++)
            pixel_q.push_back(rand_pixel(start_pct));
        pixels_sent += count;
    endtask

    task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned tw,
                             int unsigned th, int count, idle_mode_t mode);
        drain();
        idle_mode = mode;
        load_sizes(sw, sh, tw, th);
        send_pixels(count, 2);
    endtask

    initial
    begin
        bxd_pkg::in_item_t px;
        int unsigned sw, sh;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        hold_req    = 1'b0;
        fail_count  = 0;
        quiet_cycles = 0;
        pixels_sent = 0;
        idle_mode   = IDLE_NONE;
        reg_sw = 1; reg_sh = 1; reg_tw = 1; reg_th = 1;
        for (int i = 0; i < TGT_MAX; i++)
        begin
            band_r[i] = 0; band_g[i] = 0; band_b[i] = 0;
        end
        restart_frame();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset sizes: every pixel is its own cell; channel extremes and frame_start.
        for (int i = 0; i < 8; i++)
        begin
            px.frame_start = i[0];
            px.red_in      = i[1] ? 8'hFF : 8'h00;
            px.green_in    = i[2] ? 8'hFF : 8'h00;
            px.blue_in     = i[0] ? 8'h00 : 8'hFF;
            pixel_q.push_back(px);
        end
        pixels_sent += 8;

        // Small grid with a frame_start landing mid-frame.
        run_phase(4, 4, 2, 2, 0, IDLE_NONE);
        for (int i = 0; i < 14; i++)
        begin
            px = rand_pixel(0);
            px.frame_start = (i == 6);
            pixel_q.push_back(px);
        end
        pixels_sent += 14;

        // Size extremes, zero and out-of-range values that must be clamped.
        run_phase(0, 0, 0, 0, 20, IDLE_NONE);
        run_phase(8191, 1, 511, 1, 160, IDLE_SENDER);
        run_phase(4096, 1, 256, 1, 120, IDLE_RECEIVER);
        run_phase(5, 4096, 300, 256, 170, IDLE_BOTH);
        run_phase(3, 3, 7, 9, 30, IDLE_NONE);

        // Long hold-off: the block fills and stalls its input.
        run_phase(6, 4, 3, 2, 60, IDLE_NONE);
        hold_req = 1'b1;

        // Random small sizes, mostly whole frames, phases cycling the idle modes.
        for (int p = 0; pixels_sent < 1650; p++)
        begin
            sw = $urandom_range(12, 1);
            sh = $urandom_range(12, 1);
            run_phase(sw, sh, $urandom_range(14), $urandom_range(14),
                      sw * sh * $urandom_range(3, 1) + $urandom_range(6),
                      idle_mode_t'(p % 4));
        end

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
